>>> hw/rtl/kvm_pkg.sv
// Shared types and codes for the keyed value map.
package kvm_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_DUP     = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic               active;
    logic               hit;
    logic               free_taken;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] rd_value;
  } token_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic clr;
  } cell_ctl_t;

endpackage

>>> hw/rtl/kvm_cell.sv
// One slot of the map: holds a key and value, checks the passing token and hands it on.
module kvm_cell import kvm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  token_t             tok_in,
  output token_t             tok_out,
  input  cell_ctl_t          ctl,
  input  logic [KEY_W-1:0]   wr_key,
  input  logic [VALUE_W-1:0] wr_value,
  output logic               occupied
);

  logic               valid;
  logic [KEY_W-1:0]   slot_key;
  logic [VALUE_W-1:0] slot_value;
  logic               sel_hit;
  logic               sel_free;
  logic               match;
  logic               my_free;
  token_t             tok_next;

  assign occupied = valid;
  assign match    = valid && (slot_key == tok_in.key);
  assign my_free  = !valid && !tok_in.free_taken;

  always_comb begin
    tok_next            = tok_in;
    tok_next.hit        = tok_in.hit | match;
    tok_next.free_taken = tok_in.free_taken | !valid;
    tok_next.rd_value   = match ? slot_value : tok_in.rd_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.hit        <= tok_next.hit;
    tok_out.free_taken <= tok_next.free_taken;
    tok_out.key        <= tok_next.key;
    tok_out.rd_value   <= tok_next.rd_value;
  end

  always_ff @(posedge clk) begin
    if (tok_in.active) begin
      sel_hit  <= match;
      sel_free <= my_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins && sel_free) begin
      valid <= 1'b1;
    end else if (ctl.rem && sel_hit) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && sel_free) begin
      slot_key   <= wr_key;
      slot_value <= wr_value;
    end
  end

endmodule

>>> hw/rtl/keyed_value_map.sv
// Top level of the keyed value map: request control, slot chain and result register.
// A bounded map from 32-bit keys to 32-bit values held in a row of CAPACITY identical
// slot cells. Insert, lookup and remove send a token down the row, one cell per cycle;
// each cell compares its key, marks itself if it matches or is the lowest free slot, and
// hands the token on. When the token leaves the last cell the result is decided and the
// marked cells are written back together. Such a request occupies the block for the walk
// through the row and the write-back; clear skips the walk. Either waits in write-back
// while the result register is full and stalled. The result register lets the next
// request enter while a result still waits to be taken. An insert into a full map
// answers "store full" and changes nothing; a duplicate key wins over full.
module keyed_value_map import kvm_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                opcode,
  input  logic signed [KEY_W-1:0]   key,
  input  logic signed [VALUE_W-1:0] entry_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] found_value,
  output logic [COUNT_W-1:0]        entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t             state;
  state_t             state_next;
  opcode_t            req_op;
  logic [KEY_W-1:0]   req_key;
  logic [VALUE_W-1:0] req_value;
  logic               res_hit;
  logic               res_free;
  logic [VALUE_W-1:0] res_value;
  logic [CNT_W-1:0]   held_count;
  logic [CNT_W-1:0]   held_count_next;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  token_t             tok [0:CAPACITY];
  logic [CAPACITY-1:0] occupied;
  cell_ctl_t          commit_ctl;
  logic               accept;
  logic               load_ok;
  logic               commit;
  status_t            res_status;
  logic [VALUE_W-1:0] res_rd;

  assign accept = in_valid && !in_stall;

  always_comb begin
    tok[0].active     = accept && (opcode_t'(opcode) != OP_CLEAR);
    tok[0].hit        = 1'b0;
    tok[0].free_taken = 1'b0;
    tok[0].key        = $unsigned(key);
    tok[0].rd_value   = '0;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .ctl      (commit_ctl),
      .wr_key   (req_key),
      .wr_value (req_value),
      .occupied (occupied[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (opcode_t'(opcode) == OP_CLEAR) ? S_COMMIT : S_WALK;
        end
      end
      S_WALK: begin
        if (tok[CAPACITY].active) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (load_ok) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and result decision
  always_comb begin
    in_stall   = (state != S_IDLE);
    load_ok    = !out_valid || !out_stall;
    commit     = (state == S_COMMIT) && load_ok;
    commit_ctl = '0;
    res_status = STAT_OK;
    res_rd     = '0;
    unique case (req_op)
      OP_INSERT: begin
        if (res_hit) begin
          res_status = STAT_DUP;
        end else if (!res_free) begin
          res_status = STAT_FULL;
        end else begin
          commit_ctl.ins = commit;
        end
      end
      OP_LOOKUP: begin
        if (res_hit) begin
          res_rd = res_value;
        end else begin
          res_status = STAT_MISSING;
        end
      end
      OP_REMOVE: begin
        if (res_hit) begin
          res_rd         = res_value;
          commit_ctl.rem = commit;
        end else begin
          res_status = STAT_MISSING;
        end
      end
      OP_CLEAR: begin
        commit_ctl.clr = commit;
      end
      default: res_status = STAT_OK;
    endcase
  end

  always_comb begin
    held_count_next = held_count;
    if (commit_ctl.clr) begin
      held_count_next = '0;
    end else if (commit_ctl.ins) begin
      held_count_next = held_count + CNT_W'(1);
    end else if (commit_ctl.rem) begin
      held_count_next = held_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= opcode_t'(opcode);
      req_key   <= $unsigned(key);
      req_value <= $unsigned(entry_value);
    end
    if (state == S_WALK && tok[CAPACITY].active) begin
      res_hit   <= tok[CAPACITY].hit;
      res_free  <= tok[CAPACITY].free_taken;
      res_value <= tok[CAPACITY].rd_value;
    end
  end

  assign count_wide = {{COUNT_W{1'b0}}, held_count_next};

  always_ff @(posedge clk) begin
    if (commit) begin
      status      <= res_status;
      found_value <= $signed(res_rd);
      entry_count <= count_wide[COUNT_W-1:0];
    end
  end

  logic [CAPACITY:0] tok_active;
  for (genvar j = 0; j <= CAPACITY; j++) begin : g_act
    assign tok_active[j] = tok[j].active;
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(occupied) == held_count)
    else $error("entry count differs from occupied slots");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_active))
    else $error("more than one token in the slot row");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    commit_ctl.ins |=> held_count == $past(held_count) + CNT_W'(1))
    else $error("insert did not add one entry");

  a_walk_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (tok_active[CAPACITY:1] == '0))
    else $error("token in flight while idle");

endmodule

>>> test/keyed_value_map_tb.sv
// Self-checking testbench for keyed_value_map: directed edge cases and random map traffic.
module keyed_value_map_tb;
  import kvm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } map_answer_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                opcode;
  logic signed [KEY_W-1:0]   key;
  logic signed [VALUE_W-1:0] entry_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] found_value;
  logic [COUNT_W-1:0]        entry_count;

  keyed_value_map #(.CAPACITY(MAP_DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .key         (key),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_value (found_value),
    .entry_count (entry_count)
  );

  bit                 slot_used [MAP_DEPTH];
  logic [KEY_W-1:0]   slot_keys [MAP_DEPTH];
  logic [VALUE_W-1:0] slot_vals [MAP_DEPTH];
  int unsigned        held;

  map_answer_t  pending_answers [$];
  int unsigned  fail_count;
  int unsigned  sent_count;
  int unsigned  answer_count;
  int unsigned  status_seen [4];
  int unsigned  cycle_count;
  bit           src_quiet;
  bit           sink_quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("keyed_value_map regression: fail");
    $finish;
  end

  function automatic int unsigned span_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int unsigned run_left;
    bit          run_stalled;
    run_left = 0;
    run_stalled = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        run_stalled = !run_stalled && !sink_quiet && ($urandom_range(0, 2) != 0);
        run_left = run_stalled ? 1 + span_len() : $urandom_range(1, 16);
      end
      run_left--;
      out_stall <= run_stalled;
    end
  end

  function automatic map_answer_t map_apply(opcode_t op, logic [KEY_W-1:0] k,
                                            logic [VALUE_W-1:0] v);
    map_answer_t ans;
    int          hit;
    int          vacant;
    ans.status = STAT_OK;
    ans.value  = '0;
    hit = -1;
    vacant = -1;
    for (int i = MAP_DEPTH - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_keys[i] == k) hit = i;
      if (!slot_used[i]) vacant = i;
    end
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < MAP_DEPTH; i++) slot_used[i] = 1'b0;
        held = 0;
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          ans.status = STAT_DUP;
        end else if (vacant < 0) begin
          ans.status = STAT_FULL;
        end else begin
          slot_used[vacant] = 1'b1;
          slot_keys[vacant] = k;
          slot_vals[vacant] = v;
          held++;
        end
      end
      default: begin
        if (hit < 0) begin
          ans.status = STAT_MISSING;
        end else begin
          ans.value = slot_vals[hit];
          if (op == OP_REMOVE) begin
            slot_used[hit] = 1'b0;
            held--;
          end
        end
      end
    endcase
    ans.count = COUNT_W'(held);
    return ans;
  endfunction

  always @(posedge clk) begin
    map_answer_t want;
    if (!rst && out_valid && !out_stall) begin
      answer_count++;
      status_seen[status]++;
      if (pending_answers.size() == 0) begin
        $error("result beat with no request outstanding");
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (found_value !== want.value) begin
          $error("found_value: expected %h, got %h", want.value, found_value);
          fail_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          fail_count++;
        end
      end
    end
  end

  task automatic send_request(opcode_t op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    int unsigned gap;
    gap = src_quiet ? 0 : span_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    key         <= k;
    entry_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(map_apply(op, k, v));
    sent_count++;
  endtask

  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic opcode_t pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 42) return OP_INSERT;
    if (r < 70) return OP_LOOKUP;
    if (r < 98) return OP_REMOVE;
    return OP_CLEAR;
  endfunction

  task automatic test_empty_map();
    send_request(OP_LOOKUP, 32'd5, 32'd0);
    send_request(OP_REMOVE, 32'd5, 32'hFFFF_FFFF);
    finish_phase();
  endtask

  task automatic test_key_extremes();
    send_request(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_LOOKUP, 32'h8000_0000, 32'h0);
    send_request(OP_REMOVE, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    finish_phase();
  endtask

  task automatic test_full_map();
    for (int i = held; i < MAP_DEPTH; i++) send_request(OP_INSERT, 32'd100 + i, $urandom());
    send_request(OP_INSERT, 32'd999, 32'hA5A5_A5A5);
    send_request(OP_INSERT, 32'd100 + MAP_DEPTH - 1, 32'h5A5A_5A5A);
    send_request(OP_CLEAR, 32'd0, 32'd0);
    finish_phase();
  endtask

  task automatic test_random_mix(int unsigned n, int unsigned pool_size);
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] k;
    for (int i = 0; i < pool_size; i++) pool.push_back($urandom());
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'hFFFF_FFFF;
    pool[3] = 32'h0000_0000;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, pool_size - 1)];
      send_request(pick_op(), k, $urandom());
    end
    finish_phase();
  endtask

  task automatic test_streaming(int unsigned n);
    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    test_random_mix(n, 20);
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    opcode      <= OP_INSERT;
    key         <= '0;
    entry_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_map();
    test_key_extremes();
    test_full_map();
    test_random_mix(300, 24);
    test_streaming(200);
    test_random_mix(200, 6);
    test_random_mix(200, 40);

    repeat (MAP_DEPTH + 8) @(posedge clk);
    $display("%0d requests checked in %0d cycles: %0d ok, %0d duplicate, %0d missing, %0d full",
             answer_count, cycle_count, status_seen[STAT_OK], status_seen[STAT_DUP],
             status_seen[STAT_MISSING], status_seen[STAT_FULL]);
    $display("%0d field mismatches or unexpected result beats", fail_count);
    if (fail_count == 0 && answer_count == sent_count) begin
      $display("keyed_value_map regression: pass");
    end else begin
      $display("keyed_value_map regression: fail");
    end
    $finish;
  end

endmodule
